// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/asm_lex_pkg.sv =====
package asm_lex_pkg;

  // Token kinds
  localparam logic [5:0] K_UNCLASS  = 6'd0;
  localparam logic [5:0] K_COLON    = 6'd26;
  localparam logic [5:0] K_COLON_EQ = 6'd27;
  localparam logic [5:0] K_NAME     = 6'd28;
  localparam logic [5:0] K_IMM      = 6'd29;
  localparam logic [5:0] K_TOO_LONG = 6'd33;

  // Keyword table: text is right-aligned, first character in the highest used byte
  localparam int KW_NUM   = 28;
  localparam int KW_CHARS = 14;

  localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_NUM] = '{
    ".at", ".id", "end", "int", "low", "seg", "base", "bind", "data", "halt",
    "high", "load", "extra", "label", "stack", ".entry", "segend", "source",
    ".prefix", ".sizeof", ".suffix", "counter", "general", "pointer", "segment",
    "accumulator", "destination", {".prepend", "_entry"}
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd11, 4'd11, 4'd14
  };

  localparam logic [5:0] KW_KIND [KW_NUM] = '{
    6'd3, 6'd32, 6'd9, 6'd24, 6'd11, 6'd13, 6'd21, 6'd10, 6'd23, 6'd25,
    6'd12, 6'd30, 6'd22, 6'd8, 6'd20, 6'd7, 6'd2, 6'd18,
    6'd5, 6'd4, 6'd6, 6'd16, 6'd17, 6'd15, 6'd1,
    6'd14, 6'd19, 6'd31
  };

  // Which token an emit command sends
  typedef enum logic [1:0] {
    EM_COLON_HELD = 2'd0,
    EM_WORD       = 2'd1,
    EM_NAME       = 2'd2,
    EM_COLON_FIN  = 2'd3
  } emit_sel_t;

  typedef struct packed {
    logic      accept;
    logic      proc;
    logic      emit;
    emit_sel_t sel;
    logic      last;
    logic      name_next;
    logic      done;
  } lex_cmd_t;

  typedef struct packed {
    logic out_free;
    logic held_colon;
    logic word_tok;
    logic word_name;
    logic fin_colon;
    logic name_last;
  } lex_status_t;

endpackage

// ===== hw/rtl/asm_lex_ram.sv =====
module asm_lex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry through a register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== hw/rtl/asm_lex_ctrl.sv =====
`include "assert_macros.svh"

module asm_lex_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  asm_lex_pkg::lex_status_t status,
  output asm_lex_pkg::lex_cmd_t    cmd
);

  import asm_lex_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PROC   = 8'b0000_0010,
    S_HELD   = 8'b0000_0100,
    S_WORD   = 8'b0000_1000,
    S_NRD    = 8'b0001_0000,
    S_NEMIT  = 8'b0010_0000,
    S_FCOLON = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  state_t after_held, after_word;

  // Pick the next token source after each group of results
  always_comb begin
    if (status.fin_colon) after_word = S_FCOLON;
    else                  after_word = S_DONE;
    if (status.word_tok)  after_held = status.word_name ? S_NRD : S_WORD;
    else                  after_held = after_word;
  end

  // Sequence one input transaction through its results
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = EM_WORD;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (in_tvalid) state_nxt = S_PROC;
      end
      S_PROC: begin
        cmd.proc  = 1'b1;
        state_nxt = S_HELD;
      end
      S_HELD: begin
        if (!status.held_colon) begin
          state_nxt = after_held;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_COLON_HELD;
          cmd.last  = !status.word_tok && !status.fin_colon;
          state_nxt = after_held;
        end
      end
      S_WORD: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_WORD;
          cmd.last  = !status.fin_colon;
          state_nxt = after_word;
        end
      end
      S_NRD: begin
        state_nxt = S_NEMIT;
      end
      S_NEMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_NAME;
          cmd.last = status.name_last && !status.fin_colon;
          if (status.name_last) begin
            state_nxt = after_word;
          end else begin
            cmd.name_next = 1'b1;
            state_nxt     = S_NRD;
          end
        end
      end
      S_FCOLON: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_COLON_FIN;
          cmd.last  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CLK(a_emit_slot_free, cmd.emit |-> status.out_free, "emit while output slot busy")

endmodule

// ===== hw/rtl/asm_lex_dp.sv =====
`include "assert_macros.svh"

module asm_lex_dp #(
  parameter int MAX_WORD_CHARS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [7:0]               in_tdata,
  input  logic                     in_tlast,
  input  asm_lex_pkg::lex_cmd_t    cmd,
  output asm_lex_pkg::lex_status_t status,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic [119:0]             out_tdata,
  output logic                     out_tlast
);

  import asm_lex_pkg::*;

  localparam int LEN_W = $clog2(MAX_WORD_CHARS + 1);
  localparam int AW    = $clog2(MAX_WORD_CHARS);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_CHARS);

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (is_digit(c))                  v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else                              v = 5'h10;
    return v;
  endfunction

  // Input capture and lexer state
  logic [7:0]       char_r;
  logic             fin_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic [31:0]      line_r, line_nxt;
  logic             cmt_r, cmt_nxt;
  logic             pend_r, pend_nxt;
  logic [31:0]      pend_line_r, pend_line_nxt;
  logic             held_r, held_nxt;
  logic             held_eq_r, held_eq_nxt;
  logic [31:0]      held_line_r, held_line_nxt;
  logic             flush_r, flush_nxt;
  logic             fcolon_r, fcolon_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;

  // Running word classification
  logic [KW_NUM-1:0] kw_r, kw_nxt;
  logic              neg_r, neg_nxt;
  logic              hex_r, hex_nxt;
  logic              dig_r, dig_nxt;
  logic              bad_r, bad_nxt;
  logic              sat_r, sat_nxt;
  logic [63:0]       val_r, val_nxt;
  logic              nm_r, nm_nxt;

  logic             append;
  logic             is_space;
  logic [4:0]       hv;
  logic [67:0]      dec;
  logic [3:0]       kidx;
  logic             kw_hit;
  logic [5:0]       kw_kind;
  logic             imm_ok;
  logic [63:0]      imm_mag;
  logic [63:0]      imm_value;
  logic [5:0]       word_kind;
  logic [7:0]       ram_rdata;

  logic             out_valid_r;
  logic [5:0]       o_kind_r;
  logic [31:0]      o_line_r;
  logic [63:0]      o_imm_r;
  logic [7:0]       o_char_r;
  logic [4:0]       o_pos_r;
  logic             o_last_r;

  assign is_space = (char_r == CH_SPACE) || (char_r >= 8'd9 && char_r <= 8'd13);

  // Step the lexer on one captured byte; advance the name index and clear state at close
  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    line_nxt      = line_r;
    cmt_nxt       = cmt_r;
    pend_nxt      = pend_r;
    pend_line_nxt = pend_line_r;
    held_nxt      = held_r;
    held_eq_nxt   = held_eq_r;
    held_line_nxt = held_line_r;
    flush_nxt     = flush_r;
    fcolon_nxt    = fcolon_r;
    idx_nxt       = idx_r;
    append        = 1'b0;
    if (cmd.proc) begin
      line_nxt      = line_r + {31'd0, char_r == CH_NL};
      held_nxt      = pend_r;
      held_eq_nxt   = char_r == CH_EQ;
      held_line_nxt = pend_line_r;
      pend_nxt      = 1'b0;
      flush_nxt     = 1'b0;
      fcolon_nxt    = 1'b0;
      if (!(pend_r && char_r == CH_EQ)) begin
        if (cmt_r) begin
          if (char_r == CH_BSL) cmt_nxt = 1'b0;
        end else if (char_r == CH_BSL) begin
          flush_nxt = 1'b1;
          cmt_nxt   = 1'b1;
        end else if (is_space) begin
          flush_nxt = 1'b1;
        end else if (char_r == CH_COLON) begin
          flush_nxt = 1'b1;
          if (fin_r) begin
            fcolon_nxt = 1'b1;
          end else begin
            pend_nxt      = 1'b1;
            pend_line_nxt = line_nxt;
          end
        end else if (len_r < MAX_LEN) begin
          append  = 1'b1;
          len_nxt = len_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      if (fin_r) begin
        flush_nxt = 1'b1;
        cmt_nxt   = 1'b0;
        pend_nxt  = 1'b0;
      end
    end
    if (cmd.name_next) idx_nxt = idx_r + 1'b1;
    if (cmd.done) begin
      if (flush_r) begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
        idx_nxt = '0;
      end
      if (fin_r) begin
        line_nxt      = '0;
        pend_line_nxt = '0;
      end
    end
  end

  // Track keyword, immediate and name forms as characters arrive
  always_comb begin
    kw_nxt  = kw_r;
    neg_nxt = neg_r;
    hex_nxt = hex_r;
    dig_nxt = dig_r;
    bad_nxt = bad_r;
    sat_nxt = sat_r;
    val_nxt = val_r;
    nm_nxt  = nm_r;
    hv      = hex_val(char_r);
    dec     = {1'b0, val_r, 3'b0} + {3'b0, val_r, 1'b0} + {64'd0, 4'(char_r - 8'h30)};
    kidx    = '0;
    if (append) begin
      for (int k = 0; k < KW_NUM; k++) begin
        kidx      = KW_LEN[k] - 4'd1 - len_r[3:0];
        kw_nxt[k] = kw_r[k] && (len_r < LEN_W'(KW_LEN[k]))
                    && (KW_TEXT[k][{kidx, 3'b000} +: 8] == char_r);
      end
      if (len_r == '0) begin
        nm_nxt = is_alpha(char_r) || char_r == CH_UNDER;
      end else begin
        nm_nxt = nm_r && (is_alpha(char_r) || is_digit(char_r) || char_r == CH_UNDER);
      end
      if (len_r == '0 && char_r == CH_MINUS) begin
        neg_nxt = 1'b1;
      end else if (char_r == CH_DOLLAR && !hex_r && !dig_r
                   && (len_r == '0 || (len_r == LEN_W'(1) && neg_r))) begin
        hex_nxt = 1'b1;
      end else begin
        dig_nxt = 1'b1;
        if (hex_r) begin
          if (hv[4])                 bad_nxt = 1'b1;
          else if (val_r[63:60] != '0) sat_nxt = 1'b1;
          else                       val_nxt = {val_r[59:0], hv[3:0]};
        end else begin
          if (!is_digit(char_r))     bad_nxt = 1'b1;
          else if (dec[67:64] != '0) sat_nxt = 1'b1;
          else                       val_nxt = dec[63:0];
        end
      end
    end
    if (cmd.done && flush_r) begin
      kw_nxt  = '1;
      neg_nxt = 1'b0;
      hex_nxt = 1'b0;
      dig_nxt = 1'b0;
      bad_nxt = 1'b0;
      sat_nxt = 1'b0;
      val_nxt = '0;
      nm_nxt  = 1'b0;
    end
  end

  // Resolve the finished word
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = K_UNCLASS;
    for (int k = 0; k < KW_NUM; k++) begin
      if (kw_r[k] && len_r == LEN_W'(KW_LEN[k])) begin
        kw_hit  = 1'b1;
        kw_kind = kw_kind | KW_KIND[k];
      end
    end
    imm_ok    = dig_r && !bad_r;
    imm_mag   = sat_r ? '1 : val_r;
    imm_value = neg_r ? (~imm_mag + 64'd1) : imm_mag;
    if (ovf_r)       word_kind = K_TOO_LONG;
    else if (kw_hit) word_kind = kw_kind;
    else if (imm_ok) word_kind = K_IMM;
    else if (nm_r)   word_kind = K_NAME;
    else             word_kind = K_UNCLASS;
  end

  always_comb begin
    status.out_free   = !out_valid_r || out_tready;
    status.held_colon = held_r;
    status.word_tok   = flush_r && (len_r != '0 || ovf_r);
    status.word_name  = !ovf_r && !kw_hit && !imm_ok && nm_r;
    status.fin_colon  = fcolon_r;
    status.name_last  = ({1'b0, idx_r} + 1'b1) == (AW + 1)'(len_r);
  end

  asm_lex_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WORD_CHARS)
  ) u_word_ram (
    .clk     (clk),
    .we      (append),
    .waddr   (len_r[AW-1:0]),
    .wdata   (char_r),
    .raddr   (idx_r),
    .rdata_r (ram_rdata)
  );

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_r <= in_tdata;
      fin_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      line_r      <= '0;
      cmt_r       <= 1'b0;
      pend_r      <= 1'b0;
      pend_line_r <= '0;
      held_r      <= 1'b0;
      held_eq_r   <= 1'b0;
      held_line_r <= '0;
      flush_r     <= 1'b0;
      fcolon_r    <= 1'b0;
      idx_r       <= '0;
      kw_r        <= '1;
      neg_r       <= 1'b0;
      hex_r       <= 1'b0;
      dig_r       <= 1'b0;
      bad_r       <= 1'b0;
      sat_r       <= 1'b0;
      val_r       <= '0;
      nm_r        <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      line_r      <= line_nxt;
      cmt_r       <= cmt_nxt;
      pend_r      <= pend_nxt;
      pend_line_r <= pend_line_nxt;
      held_r      <= held_nxt;
      held_eq_r   <= held_eq_nxt;
      held_line_r <= held_line_nxt;
      flush_r     <= flush_nxt;
      fcolon_r    <= fcolon_nxt;
      idx_r       <= idx_nxt;
      kw_r        <= kw_nxt;
      neg_r       <= neg_nxt;
      hex_r       <= hex_nxt;
      dig_r       <= dig_nxt;
      bad_r       <= bad_nxt;
      sat_r       <= sat_nxt;
      val_r       <= val_nxt;
      nm_r        <= nm_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_last_r <= cmd.last;
      o_imm_r  <= '0;
      o_char_r <= '0;
      o_pos_r  <= '0;
      case (cmd.sel)
        EM_COLON_HELD: begin
          o_kind_r <= held_eq_r ? K_COLON_EQ : K_COLON;
          o_line_r <= held_line_r;
        end
        EM_WORD: begin
          o_kind_r <= word_kind;
          o_line_r <= line_r;
          if (word_kind == K_IMM) o_imm_r <= imm_value;
        end
        EM_NAME: begin
          o_kind_r <= K_NAME;
          o_line_r <= line_r;
          o_char_r <= ram_rdata;
          o_pos_r  <= 5'(idx_r);
        end
        default: begin
          o_kind_r <= K_COLON;
          o_line_r <= line_r;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {5'd0, o_pos_r, o_char_r, o_imm_r, o_line_r, o_kind_r};

  `ASSERT_CLK(a_len_bound, len_r <= MAX_LEN, "word length past buffer size")
  `ASSERT_CLK(a_name_idx, (cmd.emit && cmd.sel == EM_NAME) |-> ((AW + 1)'(idx_r) < (AW + 1)'(len_r)),
              "name read past word end")
  `ASSERT_CLK(a_fin_clear, (cmd.done && fin_r) |=> (line_r == '0 && !pend_r && !cmt_r),
              "state not cleared after final byte")

endmodule

// ===== hw/rtl/assembler_source_lexer.sv =====
// Assembler source lexer.
// Input channel: one source byte per transaction on in_tdata; in_tlast marks
// the last byte of a text, which flushes any pending word and colon and then
// returns the line count and the word, comment and pending colon state to their reset values.
// Output channel: one token per transaction; a name gives one transaction per
// character. out_tlast marks the last token caused by one input byte.
// Steps: a byte passes through capture, lex, held colon and close; a held colon
// token goes out in the held colon step at no extra cost. A word token and a final
// colon each have their own step, and a name character has a read and an emit step,
// set by the registered read of the word buffer RAM.
// The input is taken only while the sequencer is idle; a new byte can be
// accepted while the last token still waits in the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset (rst_n low, synchronous) clears the line count, the word, comment and
// colon state; the word buffer needs no clearing.
module assembler_source_lexer #(
  parameter int MAX_WORD_CHARS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_code
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // [5:0] token_kind, [37:6] line_number,
                                   // [101:38] immediate_value, [109:102] name_char,
                                   // [114:110] char_position, rest zero
  output logic         out_tlast
);

  import asm_lex_pkg::*;

  lex_cmd_t    cmd;
  lex_status_t status;

  asm_lex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .status    (status),
    .cmd       (cmd)
  );

  asm_lex_dp #(
    .MAX_WORD_CHARS (MAX_WORD_CHARS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assign in_tready = cmd.accept;

endmodule

// ===== test/lexer_checker.sv =====
module lexer_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           tokens_waiting
);
  import asm_lex_pkg::*;

  localparam int WORD_MAX = 32;

  typedef struct {
    logic [5:0]  kind;
    logic [31:0] line;
    logic [63:0] imm;
    logic [7:0]  ch;
    logic [4:0]  pos;
    logic        last;
  } token_t;

  token_t      token_q[$];
  logic [7:0]  word_chars[WORD_MAX];
  int          word_len;
  logic        word_long;
  logic [31:0] lines;
  logic        comment_open;
  logic        colon_held;
  logic [31:0] colon_at;

  assign tokens_waiting = token_q.size();

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (is_dec(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic push_token(logic [5:0] k, logic [31:0] ln, logic [63:0] v,
                            logic [7:0] c, logic [4:0] p);
    token_t t;
    t.kind = k; t.line = ln; t.imm = v; t.ch = c; t.pos = p; t.last = 1'b0;
    token_q.push_back(t);
  endtask

  // Classify the buffered word and queue its tokens
  task automatic close_word();
    int     p;
    int     d;
    logic   neg, hex, sat, ok, found, nm;
    logic [63:0] v;
    if (word_len == 0 && !word_long) return;
    if (word_long) begin
      push_token(K_TOO_LONG, lines, '0, '0, '0);
    end else begin
      found = 1'b0;
      for (int k = 0; k < KW_NUM && !found; k++) begin
        if (KW_LEN[k] == word_len) begin
          ok = 1'b1;
          for (int i = 0; i < word_len; i++)
            if (KW_TEXT[k][(word_len-1-i)*8 +: 8] != word_chars[i]) ok = 1'b0;
          if (ok) begin
            push_token(KW_KIND[k], lines, '0, '0, '0);
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        p = 0; neg = 0; hex = 0; sat = 0; v = '0; ok = 1'b1;
        if (p < word_len && word_chars[p] == "-") begin neg = 1; p++; end
        if (p < word_len && word_chars[p] == "$") begin hex = 1; p++; end
        if (p >= word_len) ok = 1'b0;
        for (; p < word_len && ok; p++) begin
          if (hex) begin
            d = hex_digit(word_chars[p]);
            if (d < 0) ok = 1'b0;
            else if (v[63:60] != 0) sat = 1;
            else v = {v[59:0], d[3:0]};
          end else begin
            if (!is_dec(word_chars[p])) ok = 1'b0;
            else begin
              d = word_chars[p] - "0";
              if (v > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) sat = 1;
              else v = v * 10 + d;
            end
          end
        end
        if (ok) begin
          if (sat) v = '1;
          if (neg) v = ~v + 1;
          push_token(K_IMM, lines, v, '0, '0);
        end else begin
          nm = is_letter(word_chars[0]) || word_chars[0] == "_";
          for (int i = 1; i < word_len; i++)
            if (!(is_letter(word_chars[i]) || is_dec(word_chars[i]) ||
                  word_chars[i] == "_")) nm = 0;
          if (nm) begin
            for (int i = 0; i < word_len; i++)
              push_token(K_NAME, lines, '0, word_chars[i], i[4:0]);
          end else begin
            push_token(K_UNCLASS, lines, '0, '0, '0);
          end
        end
      end
    end
    word_len = 0;
    word_long = 0;
  endtask

  // Advance the lexer state by one accepted byte
  task automatic lex_byte(logic [7:0] c, logic fin);
    int   tok_mark;
    logic used;
    tok_mark = token_q.size();
    used = 0;
    if (c == 8'h0A) lines++;
    if (colon_held) begin
      colon_held = 0;
      if (c == "=") begin
        push_token(K_COLON_EQ, colon_at, '0, '0, '0);
        used = 1;
      end else begin
        push_token(K_COLON, colon_at, '0, '0, '0);
      end
    end
    if (!used) begin
      if (comment_open) begin
        if (c == "\\") comment_open = 0;
      end else if (c == "\\") begin
        close_word();
        comment_open = 1;
      end else if (c == " " || (c >= 9 && c <= 13)) begin
        close_word();
      end else if (c == ":") begin
        close_word();
        if (fin) push_token(K_COLON, lines, '0, '0, '0);
        else begin
          colon_held = 1;
          colon_at = lines;
        end
      end else if (word_len < WORD_MAX) begin
        word_chars[word_len] = c;
        word_len++;
      end else begin
        word_long = 1;
      end
    end
    if (fin) begin
      close_word();
      lines = 0; comment_open = 0; colon_held = 0; colon_at = 0;
    end
    if (token_q.size() > tok_mark) token_q[token_q.size()-1].last = 1'b1;
  endtask

  // Watch both channels and compare tokens in order
  always @(posedge clk) begin
    token_t exp_tok;
    if (!rst_n) begin
      word_len <= 0; word_long <= 0; lines <= 0; comment_open <= 0;
      colon_held <= 0; colon_at <= 0; fail_count <= 0;
      token_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token, actual %h last %b", $time, out_tdata, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          exp_tok = token_q.pop_front();
          if (out_tdata[5:0] !== exp_tok.kind || out_tdata[37:6] !== exp_tok.line ||
              out_tdata[101:38] !== exp_tok.imm || out_tdata[109:102] !== exp_tok.ch ||
              out_tdata[114:110] !== exp_tok.pos || out_tdata[119:115] !== '0 ||
              out_tlast !== exp_tok.last) begin
            $display("%0t: mismatch expected kind %0d line %0d imm %h ch %h pos %0d last %b",
                     $time, exp_tok.kind, exp_tok.line, exp_tok.imm, exp_tok.ch,
                     exp_tok.pos, exp_tok.last);
            $display("%0t:          actual kind %0d line %0d imm %h ch %h pos %0d last %b",
                     $time, out_tdata[5:0], out_tdata[37:6], out_tdata[101:38],
                     out_tdata[109:102], out_tdata[114:110], out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) lex_byte(in_tdata, in_tlast);
    end
  end
endmodule

// ===== test/tb_assembler_source_lexer.sv =====
module tb_assembler_source_lexer;
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic         out_tlast;
  int           fail_count;
  int           tokens_waiting;
  int           cycles;
  logic         calm;

  assembler_source_lexer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  lexer_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .fail_count(fail_count), .tokens_waiting(tokens_waiting)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("tb_assembler_source_lexer: errors");
        $finish;
      end
    end
  end

  // Receiver stalls in random bursts
  initial begin
    int n;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 14);
        repeat (n) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  // Send one byte and hold until accepted
  task automatic send_byte(logic [7:0] c, logic fin);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      n = $urandom_range(1, 14);
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= c;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(string s, logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
  endtask

  // Random word: keyword, immediate, name or arbitrary bytes
  function automatic string make_word();
    string s;
    string digs;
    int n;
    int k;
    case ($urandom_range(0, 7))
      0: begin
        string kw[7] = '{"segment", {".prepend", "_entry"}, "accumulator", "load", ".id",
                         "destination", "segend"};
        s = kw[$urandom_range(0, 6)];
      end
      1: begin
        s = ($urandom_range(0, 1)) ? "-$" : "$";
        digs = "0123456789abcdefABCDEF";
        n = $urandom_range(1, 18);
        repeat (n) begin
          k = $urandom_range(0, 21);
          s = {s, digs.substr(k, k)};
        end
      end
      2: begin
        s = ($urandom_range(0, 1)) ? "-" : "";
        n = $urandom_range(1, 22);
        repeat (n) s = {s, string'(8'($urandom_range(48, 57)))};
      end
      3, 4: begin
        s = "_";
        s[0] = ($urandom_range(0, 3) == 0) ? "_" : 8'($urandom_range(97, 122));
        n = $urandom_range(0, 10);
        repeat (n) s = {s, string'(8'($urandom_range(0, 1) ? $urandom_range(65, 90)
                                                      : $urandom_range(48, 57)))};
      end
      5: begin
        n = $urandom_range(1, 40);
        s = "";
        repeat (n) s = {s, string'(8'($urandom_range(33, 255)))};
      end
      default: begin
        n = $urandom_range(1, 5);
        s = "";
        repeat (n) s = {s, "q"};
        s[0] = 8'($urandom_range(1, 255));
      end
    endcase
    return s;
  endfunction

  // Random separator
  function automatic string make_gap();
    case ($urandom_range(0, 6))
      0: return "\n";
      1: return ":";
      2: return ":=";
      3: return "\\ x\ny \\";
      4: return "\t";
      default: return " ";
    endcase
  endfunction

  initial begin
    string w;
    int sent;
    logic [7:0] b;
    calm = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tlast = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed text: keywords, immediates, names, colons, comments, overlong word
    send_text("segment .prepend", 0);
    send_text("_entry -123 $ffffffffffffffffff -$10 99999999999999999999 ", 0);
    send_text("ab_9: x:=\\c\n\\y - $ -$ a.b ", 0);
    send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ abcdefghijklmnopqrstuvwxyzABCDEF", 0);
    send_byte(8'hFF, 0);
    send_byte(8'h00, 0);
    send_text(" zz:", 1);
    in_tvalid <= 0;

    // Let every token drain before continuing
    wait (tokens_waiting == 0);
    repeat (20) @(negedge clk);

    sent = 0;
    while (sent < 70) begin
      if (sent > 50) calm = 1;
      if ($urandom_range(0, 9) == 0) begin
        b = 8'($urandom_range(0, 255));
        send_byte(b, $urandom_range(0, 8) == 0);
        sent++;
      end else begin
        w = {make_word(), make_gap()};
        send_text(w, $urandom_range(0, 12) == 0);
        sent += w.len();
      end
    end
    send_byte(" ", 1);
    in_tvalid <= 0;

    wait (tokens_waiting == 0);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_assembler_source_lexer: clean");
    end else begin
      $display("tb_assembler_source_lexer: errors");
    end
    $finish;
  end
endmodule
